// ----- hdl/xorshift_keystream_byte_cipher_assert.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the keystream byte cipher
// Shared property shapes used by the port checker.
// -----------------------------------------------------------------------------
`ifndef XORSHIFT_KEYSTREAM_BYTE_CIPHER_ASSERT_SVH
`define XORSHIFT_KEYSTREAM_BYTE_CIPHER_ASSERT_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define XKBC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent in a cycle implies the consequent in the following cycle.
`define XKBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies the consequent in the following cycle, also during reset.
`define XKBC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/xkbc_pkg.sv -----
// -----------------------------------------------------------------------------
// Keystream byte cipher package
// Constants of the generator and the command and status types shared by the
// controller and the datapath.
// -----------------------------------------------------------------------------
package xkbc_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SKIP_W  = 4;

  // Seeding offsets of the generator words b to e.
  localparam logic [WORD_W-1:0] SEED_ADD_B = 32'h159a55e5;
  localparam logic [WORD_W-1:0] SEED_ADD_C = 32'h1f123bb5;
  localparam logic [WORD_W-1:0] SEED_ADD_D = 32'h05491333;
  localparam logic [WORD_W-1:0] SEED_ADD_E = 32'h34dad465;

  // Mask on the first draw that gives the number of discarded outputs.
  localparam logic [SKIP_W-1:0] SKIP_MASK  = 4'hf;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SKIP_W-1:0] skip_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic seed;
    logic step;
    logic load_skip;
    logic dec_skip;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_start;
    logic odd;
    logic skip_zero;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/xkbc_if.sv -----
// -----------------------------------------------------------------------------
// Keystream byte cipher channels
// Valid/ready interfaces for the plain byte stream and the scrambled stream.
// -----------------------------------------------------------------------------
interface xkbc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] seed;
  logic        start_of_buffer;
  logic        end_of_buffer;

  modport source (output valid, data_byte, seed, start_of_buffer, end_of_buffer,
                  input ready);
  modport sink   (input valid, data_byte, seed, start_of_buffer, end_of_buffer,
                  output ready);
endinterface

interface xkbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ----- hdl/xkbc_datapath.sv -----
// -----------------------------------------------------------------------------
// Keystream byte cipher datapath
// Generator words, skip counter, position parity, item capture and the
// output register, all driven by controller commands.
// -----------------------------------------------------------------------------
module xkbc_datapath (
  input  logic             clk,
  input  logic             rst,
  input  xkbc_pkg::cmd_t   cmd,
  output xkbc_pkg::status_t status,
  input  logic [7:0]       data_byte,
  input  logic [31:0]      seed,
  input  logic             start_of_buffer,
  input  logic             end_of_buffer,
  xkbc_out_if.source       cipher_ch
);
  import xkbc_pkg::*;

  word_t gen_word_a, gen_word_b, gen_word_c, gen_word_d, gen_word_e;
  logic  odd_position;
  skip_t skip_count;
  byte_t key;
  byte_t item_byte;
  logic  item_last;
  logic  out_valid;
  byte_t out_byte;
  logic  out_last;

  word_t             mix_u;
  word_t             word_e_next;
  byte_t             key_next;

  // One generator step: shift-xor mix and the low byte of the output product.
  // The low byte of the product only depends on the low bytes of its factors.
  always_comb begin
    mix_u       = gen_word_a ^ (gen_word_a >> 7);
    word_e_next = mix_u ^ (mix_u << 13) ^ gen_word_e ^ (gen_word_e << 6);
    key_next    = word_e_next[BYTE_W-1:0] * {gen_word_c[BYTE_W-2:0], 1'b1};
  end

  // Generator words, parity and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_word_a   <= '0;
      gen_word_b   <= '0;
      gen_word_c   <= '0;
      gen_word_d   <= '0;
      gen_word_e   <= '0;
      odd_position <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.seed) begin
        gen_word_a <= seed;
        gen_word_b <= (seed >> 1) + SEED_ADD_B;
        gen_word_c <= (seed >> 3) + SEED_ADD_C;
        gen_word_d <= (seed >> 5) + SEED_ADD_D;
        gen_word_e <= (seed >> 7) + SEED_ADD_E;
      end else if (cmd.step) begin
        gen_word_a <= gen_word_b;
        gen_word_b <= gen_word_c;
        gen_word_c <= gen_word_d;
        gen_word_d <= gen_word_e;
        gen_word_e <= word_e_next;
      end
      if (cmd.seed) begin
        odd_position <= 1'b0;
      end else if (cmd.emit) begin
        odd_position <= ~odd_position;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (cipher_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: key, skip count, captured item and output.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      key <= key_next;
    end
    if (cmd.load_skip) begin
      skip_count <= key_next[SKIP_W-1:0] & SKIP_MASK;
    end else if (cmd.dec_skip) begin
      skip_count <= skip_count - skip_t'(1);
    end
    if (cmd.load_item) begin
      item_byte <= data_byte;
      item_last <= end_of_buffer;
    end
    if (cmd.emit) begin
      out_byte <= odd_position ? item_byte : (item_byte ^ key);
      out_last <= item_last;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.in_start  = start_of_buffer;
    status.odd       = odd_position;
    status.skip_zero = (skip_count == '0);
    status.out_free  = ~out_valid | cipher_ch.ready;
  end

  assign cipher_ch.valid    = out_valid;
  assign cipher_ch.out_byte = out_byte;
  assign cipher_ch.out_last = out_last;

endmodule

// ----- hdl/xkbc_controller.sv -----
// -----------------------------------------------------------------------------
// Keystream byte cipher controller
// Sequences seeding, the first draw, the discarded outputs, the key draw and
// the hand-over of each byte to the output register.
// -----------------------------------------------------------------------------
module xkbc_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  xkbc_pkg::status_t  status,
  output xkbc_pkg::cmd_t     cmd
);
  import xkbc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DRAW = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (status.in_start) begin
            cmd.seed   = 1'b1;
            state_next = ST_DRAW;
          end else if (status.odd) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_STEP;
          end
        end
      end
      ST_DRAW: begin
        cmd.step      = 1'b1;
        cmd.load_skip = 1'b1;
        state_next    = ST_SKIP;
      end
      ST_SKIP: begin
        if (status.skip_zero) begin
          state_next = ST_STEP;
        end else begin
          cmd.step     = 1'b1;
          cmd.dec_skip = 1'b1;
        end
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/xorshift_keystream_byte_cipher.sv -----
// -----------------------------------------------------------------------------
// Keystream byte cipher, top level
// Scrambles even-position bytes with a shift-xor keystream, passes odd ones
// unchanged; the same operation restores the original bytes.
// -----------------------------------------------------------------------------
// Usage: bytes enter on plain_ch and leave on cipher_ch, one result per
// transaction, in order. A byte with start_of_buffer set reseeds the
// generator from its seed and is taken as position 0; end_of_buffer is
// carried to out_last unchanged.
// Sequence: a byte at an odd position is handed to the output register as soon
// as it is free; one at an even position first takes a generator step for
// its key. A first byte of a buffer seeds the generator, makes the first draw
// for the skip count, discards n (0 to 15) generator outputs on the single
// generator step unit, one step a cycle, and then takes its key step.
// A new byte is accepted in the cycle after the previous one is handed to the
// output register, so bytes are worked on one at a time.
// Reset clears the generator words and the position parity, and empties the
// output register. When the receiver stalls, the result holds in the output
// register; one more byte may be accepted and waits until the register frees.
// -----------------------------------------------------------------------------
module xorshift_keystream_byte_cipher (
  input  logic       clk,
  input  logic       rst,
  xkbc_in_if.sink    plain_ch,
  xkbc_out_if.source cipher_ch
);
  import xkbc_pkg::*;

  cmd_t    cmd;
  status_t status;

  xkbc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (plain_ch.valid),
    .in_ready (plain_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  xkbc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .data_byte       (plain_ch.data_byte),
    .seed            (plain_ch.seed),
    .start_of_buffer (plain_ch.start_of_buffer),
    .end_of_buffer   (plain_ch.end_of_buffer),
    .cipher_ch       (cipher_ch)
  );

endmodule

// ----- hdl/xkbc_checker.sv -----
// -----------------------------------------------------------------------------
// Keystream byte cipher port checker
// Watches the top-level channels over time and is bound to the top level.
// -----------------------------------------------------------------------------
`include "xorshift_keystream_byte_cipher_assert.svh"

module xkbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled result keeps its payload.
  `XKBC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))

  // Reset leaves the output register empty.
  `XKBC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  // Each transaction is worked on alone: the input closes after acceptance.
  `XKBC_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // No result appears in the cycle straight after an input transaction.
  `XKBC_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && in_ready, !$rose(out_valid))

endmodule

bind xorshift_keystream_byte_cipher xkbc_checker u_xkbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (plain_ch.valid),
  .in_ready  (plain_ch.ready),
  .out_valid (cipher_ch.valid),
  .out_ready (cipher_ch.ready),
  .out_byte  (cipher_ch.out_byte),
  .out_last  (cipher_ch.out_last)
);
